FILE: hdl/mwu_pkg.sv
// Shared types and codes for the maze wall union engine.
package mwu_pkg;

  // Field widths fixed by the interface
  localparam int ROW_W  = 5;
  localparam int SIZE_W = 6;
  localparam int RV_W   = 16;
  localparam int CFG_W  = 6;
  localparam int CFGI_W = 1;

  // Direction codes as reported on out_direction
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_S = 2'd1;
  localparam logic [1:0] DIR_E = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  // Configuration register indexes
  localparam logic [CFGI_W-1:0] CFG_NUM_ROWS = 1'b0;
  localparam logic [CFGI_W-1:0] CFG_NUM_COLS = 1'b1;

  // Outcome of the direction pick for the current word
  typedef struct packed {
    logic              bad;
    logic [1:0]        dir;
    logic [SIZE_W-1:0] nbr_row;
    logic [SIZE_W-1:0] nbr_col;
  } pick_t;

endpackage

FILE: hdl/mwu_ram.sv
// Simple dual-port RAM, one write and one read port, registered read data.
module mwu_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/mwu_dir_pick.sv
// Picks an allowed direction for a cell and works out the neighbour.
module mwu_dir_pick (
  input  logic [mwu_pkg::ROW_W-1:0]  row,
  input  logic [mwu_pkg::ROW_W-1:0]  col,
  input  logic [mwu_pkg::SIZE_W-1:0] rows,
  input  logic [mwu_pkg::SIZE_W-1:0] cols,
  input  logic [mwu_pkg::RV_W-1:0]   rand_val,
  output mwu_pkg::pick_t             pick
);

  logic [mwu_pkg::SIZE_W-1:0] lr;
  logic [mwu_pkg::SIZE_W-1:0] lc;
  logic [mwu_pkg::SIZE_W-1:0] row_w;
  logic [mwu_pkg::SIZE_W-1:0] col_w;
  logic                       top_e, bot_e, lft_e, rgt_e;
  logic [1:0]                 m3;
  logic [1:0]                 dir;

  // Value mod 3: 2-bit digits have weight 4^k, which is 1 mod 3
  function automatic logic [1:0] mod3(input logic [mwu_pkg::RV_W-1:0] v);
    logic [4:0] s;
    logic [3:0] t1;
    logic [2:0] t2;
    s = '0;
    for (int i = 0; i < mwu_pkg::RV_W / 2; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t1 = 4'(s[4:2]) + 4'(s[1:0]);
    t2 = 3'(t1[3:2]) + 3'(t1[1:0]);
    if (t2 >= 3'd3) begin
      t2 = t2 - 3'd3;
    end
    return t2[1:0];
  endfunction

  assign row_w = {1'b0, row};
  assign col_w = {1'b0, col};
  assign lr    = rows - 6'd1;
  assign lc    = cols - 6'd1;
  assign top_e = (row_w == '0);
  assign bot_e = (row_w == lr);
  assign lft_e = (col_w == '0);
  assign rgt_e = (col_w == lc);
  assign m3    = mod3(rand_val);

  // Direction choice: interior first, then corners, then edges
  always_comb begin
    if (!top_e && !bot_e && !lft_e && !rgt_e) begin
      dir = rand_val[1:0];
    end else if (top_e && rgt_e) begin
      dir = rand_val[0] ? mwu_pkg::DIR_W : mwu_pkg::DIR_S;
    end else if (bot_e && lft_e) begin
      dir = rand_val[0] ? mwu_pkg::DIR_E : mwu_pkg::DIR_N;
    end else if (top_e && lft_e) begin
      dir = rand_val[0] ? mwu_pkg::DIR_E : mwu_pkg::DIR_S;
    end else if (bot_e && rgt_e) begin
      dir = rand_val[0] ? mwu_pkg::DIR_W : mwu_pkg::DIR_N;
    end else if (top_e) begin
      case (m3)
        2'd0:    dir = mwu_pkg::DIR_S;
        2'd1:    dir = mwu_pkg::DIR_E;
        default: dir = mwu_pkg::DIR_W;
      endcase
    end else if (bot_e) begin
      case (m3)
        2'd0:    dir = mwu_pkg::DIR_N;
        2'd1:    dir = mwu_pkg::DIR_E;
        default: dir = mwu_pkg::DIR_W;
      endcase
    end else if (lft_e) begin
      case (m3)
        2'd0:    dir = mwu_pkg::DIR_N;
        2'd1:    dir = mwu_pkg::DIR_S;
        default: dir = mwu_pkg::DIR_E;
      endcase
    end else begin
      case (m3)
        2'd0:    dir = mwu_pkg::DIR_N;
        2'd1:    dir = mwu_pkg::DIR_S;
        default: dir = mwu_pkg::DIR_W;
      endcase
    end
  end

  // Neighbour cell and bounds check
  always_comb begin
    pick.bad     = (row_w >= rows) || (col_w >= cols);
    pick.dir     = dir;
    pick.nbr_row = row_w;
    pick.nbr_col = col_w;
    case (dir)
      mwu_pkg::DIR_N: pick.nbr_row = row_w - 6'd1;
      mwu_pkg::DIR_S: pick.nbr_row = row_w + 6'd1;
      mwu_pkg::DIR_E: pick.nbr_col = col_w + 6'd1;
      default:        pick.nbr_col = col_w - 6'd1;
    endcase
  end

endmodule

FILE: hdl/maze_wall_union_engine.sv
// Maze wall union engine. Pulse start with a cell and a random value while
// busy is low; one result word follows, shown for exactly one cycle with
// out_valid high, and the receiver cannot stall it. The parent store is one
// RAM of MAX_ROWS*MAX_COLS entries with a registered read, and a word walks up
// to four parent chains through its single read port (the cell, its neighbour,
// and both corners), one parent link per cycle, with a union write between
// when the two roots differ; a cell outside the grid walks only the corner
// chains. Tree depth sets how long a word holds busy high. The result shows
// in the same cycle that busy falls, and the next word can be taken in that
// same cycle. After reset busy stays high while all MAX_ROWS*MAX_COLS entries
// (1024 by default) are swept so every cell is its own root; configuration
// writes are taken during that sweep.
module maze_wall_union_engine #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [mwu_pkg::ROW_W-1:0]   in_cell_row,
  input  logic [mwu_pkg::ROW_W-1:0]   in_cell_col,
  input  logic [mwu_pkg::RV_W-1:0]    in_random_value,
  output logic                        out_valid,
  output logic [1:0]                  out_direction,
  output logic                        out_wall_removed,
  output logic                        out_goal_connected,
  output logic                        out_bad_cell,
  input  logic                        cfg_we,
  input  logic [mwu_pkg::CFGI_W-1:0]  cfg_index,
  input  logic [mwu_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int NUM_CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW        = $clog2(NUM_CELLS);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ISSUE, ST_FIND, ST_UNITE
  } state_t;

  // Which chain walk is under way
  typedef enum logic [1:0] {
    PH_CELL, PH_NBR, PH_ORIGIN, PH_CORNER
  } phase_t;

  state_t                      state_r, state_nxt;
  phase_t                      phase_r, phase_nxt;
  logic [AW-1:0]               clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]               cur_r, cur_nxt;
  logic [AW-1:0]               root_a_r, root_a_nxt;
  logic [AW-1:0]               root_b_r, root_b_nxt;
  logic [AW-1:0]               root_o_r, root_o_nxt;
  logic [mwu_pkg::SIZE_W-1:0]  num_rows_r, num_cols_r;
  logic [mwu_pkg::ROW_W-1:0]   row_r, col_r;
  logic [mwu_pkg::RV_W-1:0]    rv_r;
  logic                        removed_r, removed_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [1:0]                  out_dir_r, out_dir_nxt;
  logic                        out_rem_r, out_rem_nxt;
  logic                        out_goal_r, out_goal_nxt;
  logic                        out_bad_r, out_bad_nxt;

  logic [mwu_pkg::SIZE_W-1:0]  rows_cl, cols_cl;
  mwu_pkg::pick_t              pick;
  phase_t                      issue_ph;
  logic [AW-1:0]               start_addr;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_wdata, ram_raddr, ram_q;
  logic                        accept;

  function automatic logic [AW-1:0] cell_addr(input logic [mwu_pkg::SIZE_W-1:0] r,
                                              input logic [mwu_pkg::SIZE_W-1:0] c);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  // Effective grid size: below 2 acts as 2, above the maximum as the maximum
  assign rows_cl = (num_rows_r < 6'd2) ? 6'd2 :
                   ({1'b0, num_rows_r} > 7'(MAX_ROWS)) ? 6'(MAX_ROWS) : num_rows_r;
  assign cols_cl = (num_cols_r < 6'd2) ? 6'd2 :
                   ({1'b0, num_cols_r} > 7'(MAX_COLS)) ? 6'(MAX_COLS) : num_cols_r;

  mwu_dir_pick u_pick (
    .row      (row_r),
    .col      (col_r),
    .rows     (rows_cl),
    .cols     (cols_cl),
    .rand_val (rv_r),
    .pick     (pick)
  );

  mwu_ram #(
    .WIDTH (AW),
    .DEPTH (NUM_CELLS)
  ) u_parent (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // A cell outside the grid skips straight to the corner walks
  assign issue_ph = (phase_r == PH_CELL && pick.bad) ? PH_ORIGIN : phase_r;

  // First address of each chain walk
  always_comb begin
    case (issue_ph)
      PH_CELL:   start_addr = cell_addr({1'b0, row_r}, {1'b0, col_r});
      PH_NBR:    start_addr = cell_addr(pick.nbr_row, pick.nbr_col);
      PH_ORIGIN: start_addr = '0;
      default:   start_addr = cell_addr(rows_cl - 6'd1, cols_cl - 6'd1);
    endcase
  end

  // Sequencer: sweep, issue a walk, follow parent links, unite
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    clr_cnt_nxt   = clr_cnt_r;
    cur_nxt       = cur_r;
    root_a_nxt    = root_a_r;
    root_b_nxt    = root_b_r;
    root_o_nxt    = root_o_r;
    removed_nxt   = removed_r;
    out_valid_nxt = 1'b0;
    out_dir_nxt   = out_dir_r;
    out_rem_nxt   = out_rem_r;
    out_goal_nxt  = out_goal_r;
    out_bad_nxt   = out_bad_r;
    ram_we        = 1'b0;
    ram_waddr     = clr_cnt_r;
    ram_wdata     = clr_cnt_r;
    ram_raddr     = cur_r;

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(NUM_CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          phase_nxt   = PH_CELL;
          removed_nxt = 1'b0;
          state_nxt   = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        ram_raddr = start_addr;
        cur_nxt   = start_addr;
        phase_nxt = issue_ph;
        state_nxt = ST_FIND;
      end
      ST_FIND: begin
        if (ram_q == cur_r) begin
          // Root reached
          case (phase_r)
            PH_CELL: begin
              root_a_nxt = cur_r;
              phase_nxt  = PH_NBR;
              state_nxt  = ST_ISSUE;
            end
            PH_NBR: begin
              root_b_nxt = cur_r;
              state_nxt  = ST_UNITE;
            end
            PH_ORIGIN: begin
              root_o_nxt = cur_r;
              phase_nxt  = PH_CORNER;
              state_nxt  = ST_ISSUE;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_bad_nxt   = pick.bad;
              out_dir_nxt   = pick.bad ? mwu_pkg::DIR_N : pick.dir;
              out_rem_nxt   = removed_r;
              out_goal_nxt  = (cur_r == root_o_r);
              state_nxt     = ST_IDLE;
            end
          endcase
        end else begin
          ram_raddr = ram_q;
          cur_nxt   = ram_q;
        end
      end
      ST_UNITE: begin
        // Cell's root now points at the neighbour's root
        ram_we      = (root_a_r != root_b_r);
        ram_waddr   = root_a_r;
        ram_wdata   = root_b_r;
        removed_nxt = (root_a_r != root_b_r);
        phase_nxt   = PH_ORIGIN;
        state_nxt   = ST_ISSUE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      num_rows_r  <= 6'd32;
      num_cols_r  <= 6'd32;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == mwu_pkg::CFG_NUM_ROWS) begin
        num_rows_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == mwu_pkg::CFG_NUM_COLS) begin
        num_cols_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    phase_r    <= phase_nxt;
    cur_r      <= cur_nxt;
    root_a_r   <= root_a_nxt;
    root_b_r   <= root_b_nxt;
    root_o_r   <= root_o_nxt;
    removed_r  <= removed_nxt;
    out_dir_r  <= out_dir_nxt;
    out_rem_r  <= out_rem_nxt;
    out_goal_r <= out_goal_nxt;
    out_bad_r  <= out_bad_nxt;
    if (accept) begin
      row_r <= in_cell_row;
      col_r <= in_cell_col;
      rv_r  <= in_random_value;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_direction      = out_dir_r;
  assign out_wall_removed   = out_rem_r;
  assign out_goal_connected = out_goal_r;
  assign out_bad_cell       = out_bad_r;

endmodule

FILE: tb/sv/mwu_checker.sv
// Watches the word, result and register channels of the maze wall union engine,
// keeps its own parent store and grid size, and compares every result word.
module mwu_checker #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [mwu_pkg::ROW_W-1:0]   in_cell_row,
  input  logic [mwu_pkg::ROW_W-1:0]   in_cell_col,
  input  logic [mwu_pkg::RV_W-1:0]    in_random_value,
  input  logic                        out_valid,
  input  logic [1:0]                  out_direction,
  input  logic                        out_wall_removed,
  input  logic                        out_goal_connected,
  input  logic                        out_bad_cell,
  input  logic                        cfg_we,
  input  logic [mwu_pkg::CFGI_W-1:0]  cfg_index,
  input  logic [mwu_pkg::CFG_W-1:0]   cfg_wdata,
  output int                          fail_count,
  output int                          results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int SIZE_W = mwu_pkg::SIZE_W;

  typedef struct {
    logic [1:0] direction;
    logic       wall_removed;
    logic       goal_connected;
    logic       bad_cell;
  } maze_result_t;

  maze_result_t      maze_results_q[$];
  logic [ADDR_W-1:0] parent_of [CELLS];
  logic [SIZE_W-1:0] rows_reg;
  logic [SIZE_W-1:0] cols_reg;
  int                mismatches = 0;

  assign fail_count = mismatches;

  // register value as the grid uses it
  function automatic int grid_size(logic [SIZE_W-1:0] v, int maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // walk parent links to the root of a cell's set
  function automatic int set_root(int a);
    int p;
    for (int steps = 0; steps < CELLS; steps++) begin
      p = parent_of[a];
      if (p == a) break;
      a = p;
    end
    return a;
  endfunction

  // direction among those that stay inside the grid
  function automatic logic [1:0] pick_heading(int r, int c, int rows, int cols, int rv);
    int lr;
    int lc;
    lr = rows - 1;
    lc = cols - 1;
    if (r > 0 && r != lr && c > 0 && c != lc) begin
      case (rv % 4)
        0:       return mwu_pkg::DIR_N;
        1:       return mwu_pkg::DIR_S;
        2:       return mwu_pkg::DIR_E;
        default: return mwu_pkg::DIR_W;
      endcase
    end
    if (r == 0 && c == lc) return (rv % 2) ? mwu_pkg::DIR_W : mwu_pkg::DIR_S;
    if (r == lr && c == 0) return (rv % 2) ? mwu_pkg::DIR_E : mwu_pkg::DIR_N;
    if (r == 0 && c == 0) return (rv % 2) ? mwu_pkg::DIR_E : mwu_pkg::DIR_S;
    if (r == lr && c == lc) return (rv % 2) ? mwu_pkg::DIR_W : mwu_pkg::DIR_N;
    if (r == 0) begin
      case (rv % 3)
        0:       return mwu_pkg::DIR_S;
        1:       return mwu_pkg::DIR_E;
        default: return mwu_pkg::DIR_W;
      endcase
    end
    if (r == lr) begin
      case (rv % 3)
        0:       return mwu_pkg::DIR_N;
        1:       return mwu_pkg::DIR_E;
        default: return mwu_pkg::DIR_W;
      endcase
    end
    // left and right columns: plain modulo 3
    case (rv % 3)
      0:       return mwu_pkg::DIR_N;
      1:       return mwu_pkg::DIR_S;
      default: return (c == 0) ? mwu_pkg::DIR_E : mwu_pkg::DIR_W;
    endcase
  endfunction

  // merge the cell with its neighbour and work out the result word
  task automatic knock_wall(input int r, input int c, input int rv, output maze_result_t res);
    int         rows;
    int         cols;
    int         nr;
    int         nc;
    int         ra;
    int         rb;
    logic [1:0] d;
    rows = grid_size(rows_reg, MAX_ROWS);
    cols = grid_size(cols_reg, MAX_COLS);
    res.direction    = mwu_pkg::DIR_N;
    res.wall_removed = 1'b0;
    res.bad_cell     = 1'b0;
    if (r >= rows || c >= cols) begin
      // outside the grid: store untouched
      res.bad_cell = 1'b1;
    end else begin
      d  = pick_heading(r, c, rows, cols, rv);
      nr = r;
      nc = c;
      case (d)
        mwu_pkg::DIR_N: nr = r - 1;
        mwu_pkg::DIR_S: nr = r + 1;
        mwu_pkg::DIR_E: nc = c + 1;
        default:        nc = c - 1;
      endcase
      ra = set_root(r * MAX_COLS + c);
      rb = set_root(nr * MAX_COLS + nc);
      if (ra != rb) begin
        parent_of[ra]    = rb[ADDR_W-1:0];
        res.wall_removed = 1'b1;
      end
      res.direction = d;
    end
    res.goal_connected = (set_root(0) == set_root((rows - 1) * MAX_COLS + cols - 1));
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // sample all three channels at the clock edge
  always @(posedge clk) begin : watch
    maze_result_t want;
    maze_result_t made;
    int           pushed;
    int           popped;
    pushed = 0;
    popped = 0;
    if (!rst_n) begin
      rows_reg = SIZE_W'(32);
      cols_reg = SIZE_W'(32);
      for (int i = 0; i < CELLS; i++) parent_of[i] = i[ADDR_W-1:0];
      maze_results_q.delete();
      results_due <= 0;
    end else begin
      if (out_valid) begin
        if (maze_results_q.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          want = maze_results_q.pop_front();
          popped = 1;
          check_field("direction", want.direction, out_direction);
          check_field("wall_removed", want.wall_removed, out_wall_removed);
          check_field("goal_connected", want.goal_connected, out_goal_connected);
          check_field("bad_cell", want.bad_cell, out_bad_cell);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          mwu_pkg::CFG_NUM_ROWS: rows_reg = cfg_wdata;
          mwu_pkg::CFG_NUM_COLS: cols_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        knock_wall(in_cell_row, in_cell_col, in_random_value, made);
        maze_results_q.push_back(made);
        pushed = 1;
      end
      results_due <= results_due + pushed - popped;
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// Stimulus and verdict for the maze wall union engine; checking lives in mwu_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int CFG_W    = mwu_pkg::CFG_W;
  localparam int RANDOM_PHASES   = 15;
  localparam int WORDS_PER_PHASE = 60;
  // limit on the whole run, sized for the worst word's four chain walks plus
  // overhead, sender gaps and the clearing sweep, with margin
  localparam int CYCLE_LIMIT = 16_000_000;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [mwu_pkg::ROW_W-1:0]  in_cell_row;
  logic [mwu_pkg::ROW_W-1:0]  in_cell_col;
  logic [mwu_pkg::RV_W-1:0]   in_random_value;
  logic                       out_valid;
  logic [1:0]                 out_direction;
  logic                       out_wall_removed;
  logic                       out_goal_connected;
  logic                       out_bad_cell;
  logic                       cfg_we;
  logic [mwu_pkg::CFGI_W-1:0] cfg_index;
  logic [CFG_W-1:0]           cfg_wdata;
  int                         fail_count;
  int                         results_due;
  int                         cycle_count = 0;
  bit                         idle_enabled;
  int                         grid_rows;
  int                         grid_cols;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  maze_wall_union_engine #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cell_row        (in_cell_row),
    .in_cell_col        (in_cell_col),
    .in_random_value    (in_random_value),
    .out_valid          (out_valid),
    .out_direction      (out_direction),
    .out_wall_removed   (out_wall_removed),
    .out_goal_connected (out_goal_connected),
    .out_bad_cell       (out_bad_cell),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  mwu_checker #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cell_row        (in_cell_row),
    .in_cell_col        (in_cell_col),
    .in_random_value    (in_random_value),
    .out_valid          (out_valid),
    .out_direction      (out_direction),
    .out_wall_removed   (out_wall_removed),
    .out_goal_connected (out_goal_connected),
    .out_bad_cell       (out_bad_cell),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .results_due        (results_due)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // present one word and hold it until the engine takes it
  task automatic send_word(input int row, input int col, input int rv);
    if (idle_enabled) begin
      while ($urandom_range(0, 99) < 31) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    in_cell_row     <= row[mwu_pkg::ROW_W-1:0];
    in_cell_col     <= col[mwu_pkg::ROW_W-1:0];
    in_random_value <= rv[mwu_pkg::RV_W-1:0];
    start           <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop sending and wait for every outstanding result word
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (results_due != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write both size registers back to back
  task automatic set_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_index <= mwu_pkg::CFG_NUM_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_index <= mwu_pkg::CFG_NUM_COLS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_we    <= 1'b0;
    grid_rows = (rows < 2) ? 2 : (rows > MAX_ROWS) ? MAX_ROWS : int'(rows);
    grid_cols = (cols < 2) ? 2 : (cols > MAX_COLS) ? MAX_COLS : int'(cols);
  endtask

  function automatic logic [CFG_W-1:0] extreme_size();
    case ($urandom_range(0, 5))
      0:       return CFG_W'(0);
      1:       return CFG_W'(1);
      2:       return CFG_W'(2);
      3:       return CFG_W'(32);
      4:       return CFG_W'(33);
      default: return CFG_W'(63);
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] rsz;
    logic [CFG_W-1:0] csz;
    int               row;
    int               col;
    int               kind;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_cell_row     <= '0;
    in_cell_col     <= '0;
    in_random_value <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= mwu_pkg::CFG_NUM_ROWS;
    cfg_wdata       <= '0;
    idle_enabled    = 1'b1;
    grid_rows       = 32;
    grid_cols       = 32;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset-sized grid: corners, edges and interior, random value extremes
    send_word(0, 0, 0);
    send_word(0, 0, 16'hFFFF);
    send_word(0, 31, 0);
    send_word(0, 31, 1);
    send_word(31, 0, 16'hFFFF);
    send_word(31, 31, 0);
    send_word(31, 31, 1);
    send_word(0, 7, 2);
    send_word(31, 9, 1);
    send_word(12, 0, 2);
    send_word(20, 31, 2);
    send_word(15, 16, 3);
    send_word(15, 16, 16'hFFFF);
    drain();

    // sizes below the minimum act as 2x2: cells outside, then goal reached
    set_grid(CFG_W'(0), CFG_W'(1));
    send_word(2, 0, 0);
    send_word(0, 2, 16'hFFFF);
    send_word(31, 31, 5);
    send_word(0, 0, 0);
    send_word(0, 1, 1);
    send_word(1, 0, 3);
    send_word(1, 1, 16'hFFFF);
    send_word(1, 1, 0);
    send_word(0, 0, 1);
    send_word(5, 1, 7);
    drain();

    // sizes above the maximum act as the maximum
    set_grid(CFG_W'(63), CFG_W'(33));
    send_word(31, 30, 16'hFFFE);
    drain();

    // random phases: mostly small grids, mostly in-grid cells
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        rsz = CFG_W'($urandom_range(0, 63));
        csz = CFG_W'($urandom_range(0, 63));
      end else if (kind <= 2) begin
        rsz = extreme_size();
        csz = extreme_size();
      end else begin
        rsz = CFG_W'($urandom_range(2, 8));
        csz = CFG_W'($urandom_range(2, 8));
      end
      set_grid(rsz, csz);
      idle_enabled = !(p == 4 || p == 5);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if ($urandom_range(0, 99) < 85) begin
          row = $urandom_range(0, grid_rows - 1);
          col = $urandom_range(0, grid_cols - 1);
        end else begin
          row = $urandom_range(0, 31);
          col = $urandom_range(0, 31);
        end
        send_word(row, col, $urandom_range(0, 65535));
      end
      drain();
    end

    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/mwu_pkg.sv
hdl/mwu_ram.sv
hdl/mwu_dir_pick.sv
hdl/maze_wall_union_engine.sv
tb/sv/mwu_checker.sv
tb/sv/tb_top.sv
